// File: rtl/core/asfr_pkg.sv
// shared types and constants of the addressed serial frame receiver
package asfr_pkg;

  // frame layout
  localparam logic [7:0] HDR0           = 8'hFA;
  localparam logic [7:0] HDR1           = 8'hF5;
  localparam int         TRAILER_OFFSET = 5;
  localparam int         POS_LIMIT      = 251;
  localparam int         MAX_FRAME      = 256;

  // largest length that keeps the whole frame inside both limits
  localparam int LEN_LIMIT = (MAX_FRAME - TRAILER_OFFSET < POS_LIMIT)
                             ? (MAX_FRAME - TRAILER_OFFSET) : POS_LIMIT;
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  // byte positions within a frame
  localparam logic [7:0] POS_HUNT    = 8'd0;
  localparam logic [7:0] POS_HDR1    = 8'd1;
  localparam logic [7:0] POS_LEN_HI  = 8'd2;
  localparam logic [7:0] POS_LEN_LO  = 8'd3;
  localparam logic [7:0] POS_ADDR_HI = 8'd4;
  localparam logic [7:0] POS_ADDR_LO = 8'd5;
  localparam logic [7:0] POS_PAYLOAD = 8'd6;
  localparam logic [7:0] LAST_OFFSET = 8'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_ADDRESS   = 2'd0;
  localparam logic [1:0] CFG_FIXED_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH    = 2'd2;

  typedef struct packed {
    logic [15:0] own_address;
    logic [15:0] fixed_address;
    logic [7:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic [15:0] frame_address;
    logic [7:0]  frame_length;
    logic        checksum_ok;
    logic        is_last;
    logic [7:0]  byte_index;
    logic [7:0]  payload_byte;
  } result_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

// File: rtl/core/addressed_serial_frame_receiver.sv
// top level of the addressed serial frame receiver
//
// channel  dir  signals                        content
// s_axis   in   tvalid tready tdata[7:0]      received byte
// m_axis   out  tvalid tready tdata tlast tuser  payload byte with frame info
// cfg      in   cfg_we cfg_index cfg_data      register writes, no read-back
//
// one item per cycle while s_tready is high; the parser state update and
// result build are combinational between parser state and output registers
// only payload bytes and the checksum byte give a result, one result each
// rst is synchronous active high: hunting for a header, registers at defaults
// a two-entry output buffer keeps s_tready high while one result waits;
// s_tready falls only when both entries hold a result
module addressed_serial_frame_receiver
  import asfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // payload_byte[7:0], byte_index[15:8],
                                 // frame_length[23:16], frame_address[39:24]
  output logic        m_tlast,   // is_last
  output logic        m_tuser,   // checksum_ok
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  logic        in_accept;
  logic        result_valid;
  result_t     result;
  result_t     out_data;
  logic        buf_space;
  buf_status_t buf_status;

  // configuration registers; unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address   <= 16'd1;
      cfg.fixed_address <= 16'hFFFF;
      cfg.max_length    <= 8'd251;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:   cfg.own_address   <= cfg_data;
        CFG_FIXED_ADDRESS: cfg.fixed_address <= cfg_data;
        CFG_MAX_LENGTH:    cfg.max_length    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input is taken whenever the skid entry is free
  assign s_tready  = buf_space;
  assign in_accept = s_tvalid && s_tready;

  asfr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (in_accept),
    .rx_byte      (s_tdata),
    .result_valid (result_valid),
    .result       (result)
  );

  asfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept && result_valid),
    .push_data (result),
    .space     (buf_space),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (out_data),
    .status    (buf_status)
  );

  // pack result fields onto the stream
  assign m_tdata = {out_data.frame_address, out_data.frame_length,
                    out_data.byte_index, out_data.payload_byte};
  assign m_tlast = out_data.is_last;
  assign m_tuser = out_data.checksum_ok;

`ifndef SYNTHESIS
  // skid entry only fills behind a held main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    buf_status.skid_valid |-> buf_status.main_valid)
    else $error("skid entry valid without main entry");

  // a result pushed into a full buffer would be lost
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    buf_status.skid_valid |-> !in_accept)
    else $error("input accepted while output buffer full");

  // checksum verdict only on the last byte
  a_verdict_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("checksum flag on a non-last item");

  // the last byte sits at length plus four
  a_last_position: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[15:8] == m_tdata[23:16] + LAST_OFFSET))
    else $error("last item at wrong position");
`endif

endmodule

// File: rtl/core/asfr_parser.sv
// frame parser: position tracking, length and address checks, checksum
module asfr_parser
  import asfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       result_valid,
  output result_t    result
);

  logic [7:0]  position, position_next;
  logic [7:0]  length_hi, length_hi_next;
  logic [7:0]  length_lo, length_lo_next;
  logic [15:0] address, address_next;
  logic [7:0]  xor_accum, xor_accum_next;

  logic        length_ok;
  logic        address_ok;
  logic [7:0]  last_pos;
  logic        at_last;

  assign length_ok = (length_hi == 8'd0) && (rx_byte >= MIN_LENGTH) &&
                     (rx_byte <= cfg.max_length) && (rx_byte <= 8'(LEN_LIMIT));
  assign address_ok = ({address[15:8], rx_byte} == cfg.fixed_address) ||
                      ({address[15:8], rx_byte} == 16'd0) ||
                      ({address[15:8], rx_byte} == cfg.own_address);
  assign last_pos = length_lo + LAST_OFFSET;
  assign at_last  = position >= last_pos;

  always_comb begin
    position_next  = position;
    length_hi_next = length_hi;
    length_lo_next = length_lo;
    address_next   = address;
    xor_accum_next = xor_accum ^ rx_byte;
    result_valid   = 1'b0;
    case (position)
      POS_HUNT: begin
        xor_accum_next = rx_byte;
        if (rx_byte == HDR0) position_next = POS_HDR1;
      end
      POS_HDR1: begin
        position_next = (rx_byte == HDR1) ? POS_LEN_HI : POS_HUNT;
      end
      POS_LEN_HI: begin
        length_hi_next = rx_byte;
        position_next  = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        length_lo_next = rx_byte;
        position_next  = length_ok ? POS_ADDR_HI : POS_HUNT;
      end
      POS_ADDR_HI: begin
        address_next  = {rx_byte, 8'd0};
        position_next = POS_ADDR_LO;
      end
      POS_ADDR_LO: begin
        address_next  = {address[15:8], rx_byte};
        position_next = address_ok ? POS_PAYLOAD : POS_HUNT;
      end
      default: begin
        result_valid  = 1'b1;
        position_next = at_last ? POS_HUNT : position + 8'd1;
      end
    endcase
  end

  always_comb begin
    result.payload_byte  = rx_byte;
    result.byte_index    = position;
    result.is_last       = at_last;
    result.checksum_ok   = at_last && (xor_accum == rx_byte);
    result.frame_length  = length_lo;
    result.frame_address = address;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= POS_HUNT;
      length_hi <= 8'd0;
      length_lo <= 8'd0;
      address   <= 16'd0;
      xor_accum <= 8'd0;
    end else if (accept) begin
      position  <= position_next;
      length_hi <= length_hi_next;
      length_lo <= length_lo_next;
      address   <= address_next;
      xor_accum <= xor_accum_next;
    end
  end

endmodule

// File: rtl/core/asfr_out_buf.sv
// two-entry output register with skid stage for result items
module asfr_out_buf
  import asfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  result_t     push_data,
  output logic        space,
  input  logic        pop_ready,
  output logic        out_valid,
  output result_t     out_data,
  output buf_status_t status
);

  logic    main_valid;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid && pop_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign status.main_valid = main_valid;
  assign status.skid_valid = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (main_valid) begin
        if (push && !pop) skid_valid <= 1'b1;
        else if (!push && pop) main_valid <= 1'b0;
      end else if (push) begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (push && (!main_valid || pop)) begin
      out_data <= push_data;
    end
    if (!skid_valid && main_valid && push && !pop) skid_data <= push_data;
  end

endmodule

// File: tb/tb_addressed_serial_frame_receiver.sv
// self-checking testbench for the addressed serial frame receiver
module tb_addressed_serial_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import asfr_pkg::*;

  // one row of the directed walk: the byte to send and, where it is obvious,
  // the result typed in by hand instead of taken from the frame predictor
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       typed;
    result_t    res;
  } stim_row_t;

  localparam int DIR_ROWS = 27;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // length 3, fixed address ffff, correct checksum f3
    '{8'hFA, 1'b0, '0}, '{8'hF5, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h03, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, '{16'hFFFF, 8'd3, 1'b0, 1'b0, 8'd6, 8'hFF}},
    '{8'hF3, 1'b1, '{16'hFFFF, 8'd3, 1'b1, 1'b1, 8'd7, 8'hF3}},
    // shortest frame, own address 0001, checksum byte 00 instead of 0c
    '{8'hFA, 1'b0, '0}, '{8'hF5, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'h00, 1'b1, '{16'h0001, 8'd2, 1'b0, 1'b1, 8'd6, 8'h00}},
    // second header byte wrong: the repeated fa must not start a frame
    '{8'hFA, 1'b0, '0}, '{8'hFA, 1'b0, '0},
    // length 1 is too short and drops the frame
    '{8'hFA, 1'b0, '0}, '{8'hF5, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    // address 1234 is not ours and drops the frame
    '{8'hFA, 1'b0, '0}, '{8'hF5, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
    '{8'h12, 1'b0, '0}, '{8'h34, 1'b0, '0}
  };

  // register settings of the random phases; phase 3 is drawn at random
  localparam int PHASES = 6;
  localparam cfg_t PHASE_CFG [PHASES] = '{
    '{16'h1234, 16'hFFFF, 8'd251},
    '{16'h0000, 16'h0000, 8'd2},
    '{16'hFFFF, 16'hABCD, 8'd40},
    '{16'h0000, 16'h0000, 8'd2},
    '{16'h0001, 16'hFFFF, 8'd251},
    '{16'h7E5A, 16'h0100, 8'd16}
  };
  localparam int PHASE_ITEMS = 275;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;   // payload_byte[7:0], byte_index[15:8],
                          // frame_length[23:16], frame_address[39:24]
  logic        m_tlast;   // is_last
  logic        m_tuser;   // checksum_ok
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // shadow copy of the receiver: registers and frame state
  cfg_t        cfg_shadow;
  logic [7:0]  fr_pos;
  logic [15:0] fr_len;
  logic [15:0] fr_addr;
  logic [7:0]  fr_xor;

  result_t     pending_results [$];
  result_t     want;
  int          mismatch_count = 0;
  int          sent_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;

  addressed_serial_frame_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // advances the frame state by one byte; returns 1 when the byte gives a result
  function automatic bit frame_predict(input logic [7:0] b, output result_t r);
    logic [15:0] last_pos;
    bit          produced;
    produced = 1'b0;
    r = '0;
    case (fr_pos)
      POS_HUNT: begin
        if (b == HDR0) begin
          fr_xor = b;
          fr_pos = POS_HDR1;
        end
      end
      POS_HDR1: begin
        // a mismatching byte is dropped, not looked at as a new start
        if (b == HDR1) begin
          fr_xor = fr_xor ^ b;
          fr_pos = POS_LEN_HI;
        end else begin
          fr_pos = POS_HUNT;
        end
      end
      POS_LEN_HI: begin
        fr_len = {b, 8'h00};
        fr_xor = fr_xor ^ b;
        fr_pos = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        fr_len[7:0] = b;
        fr_xor = fr_xor ^ b;
        if (fr_len >= 16'(MIN_LENGTH) && fr_len <= 16'(cfg_shadow.max_length) &&
            int'(fr_len) <= POS_LIMIT && int'(fr_len) + TRAILER_OFFSET <= MAX_FRAME) begin
          fr_pos = POS_ADDR_HI;
        end else begin
          fr_pos = POS_HUNT;
        end
      end
      POS_ADDR_HI: begin
        fr_addr = {b, 8'h00};
        fr_xor = fr_xor ^ b;
        fr_pos = POS_ADDR_LO;
      end
      POS_ADDR_LO: begin
        fr_addr[7:0] = b;
        fr_xor = fr_xor ^ b;
        if (fr_addr == cfg_shadow.fixed_address || fr_addr == 16'h0000 ||
            fr_addr == cfg_shadow.own_address) begin
          fr_pos = POS_PAYLOAD;
        end else begin
          fr_pos = POS_HUNT;
        end
      end
      default: begin
        last_pos = fr_len + 16'(LAST_OFFSET);
        r.payload_byte  = b;
        r.byte_index    = fr_pos;
        r.frame_length  = fr_len[7:0];
        r.frame_address = fr_addr;
        if ({8'h00, fr_pos} >= last_pos) begin
          // checksum byte closes the frame
          r.is_last     = 1'b1;
          r.checksum_ok = (fr_xor == b);
          fr_pos = POS_HUNT;
        end else begin
          fr_xor = fr_xor ^ b;
          fr_pos = fr_pos + 8'd1;
        end
        produced = 1'b1;
      end
    endcase
    return produced;
  endfunction

  // sends one byte with random lead-in gaps, then records what it should cause
  task automatic push_byte(input logic [7:0] b, input logic typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sent_count++;
    if (frame_predict(b, r)) begin
      pending_results.push_back(typed ? typed_res : r);
    end
  endtask

  // holds the input low until every expected result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // writes all three registers back to back; only called with the block idle
  task automatic write_regs(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_ADDRESS;
    cfg_data  <= c.own_address;
    @(posedge clk);
    cfg_index <= CFG_FIXED_ADDRESS;
    cfg_data  <= c.fixed_address;
    @(posedge clk);
    // upper byte is junk the register must ignore
    cfg_index <= CFG_MAX_LENGTH;
    cfg_data  <= {8'($urandom_range(255)), c.max_length};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  // one random unit: mostly whole frames, some cut short, bad ones and line noise
  task automatic send_random_unit();
    logic [7:0]  frame_bytes [$];
    logic [15:0] len;
    logic [15:0] addr;
    logic [7:0]  chk;
    int          kind;
    int          maxl;
    int          cut;
    kind = $urandom_range(99);
    maxl = cfg_shadow.max_length;
    if (kind >= 94) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(255)));
    end else begin
      if (kind >= 80 && kind < 88) begin
        case ($urandom_range(4))
          0: len = 16'($urandom_range(1));
          1: len = 16'(maxl + 1);
          2: len = {8'($urandom_range(1, 255)), 8'($urandom_range(255))};
          3: len = 16'($urandom_range(252, 255));
          default: len = 16'($urandom_range(255));
        endcase
      end else if ($urandom_range(9) == 0) begin
        len = 16'($urandom_range(2, maxl));
      end else begin
        len = 16'($urandom_range(2, (maxl < 12) ? maxl : 12));
      end
      if (kind >= 88) begin
        addr = 16'($urandom_range(65535));
      end else begin
        case ($urandom_range(2))
          0: addr = 16'h0000;
          1: addr = cfg_shadow.fixed_address;
          default: addr = cfg_shadow.own_address;
        endcase
      end
      frame_bytes = {HDR0, HDR1, len[15:8], len[7:0], addr[15:8], addr[7:0]};
      if (kind < 80) begin
        repeat (int'(len) - 2) frame_bytes.push_back(8'($urandom_range(255)));
        chk = 8'h00;
        foreach (frame_bytes[i]) chk = chk ^ frame_bytes[i];
        if ($urandom_range(6) == 0) chk = 8'($urandom_range(255));
        frame_bytes.push_back(chk);
        if (kind >= 70) begin
          // cut short anywhere; the next unit lands in the middle of this frame
          cut = $urandom_range(1, frame_bytes.size() - 1);
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
      end
    end
    foreach (frame_bytes[i]) push_byte(frame_bytes[i], 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // result side: compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item expected none actual tdata %h tlast %b tuser %b",
                 $time, m_tdata, m_tlast, m_tuser);
      end else begin
        want = pending_results.pop_front();
        check_field("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]));
        check_field("byte_index", 16'(want.byte_index), 16'(m_tdata[15:8]));
        check_field("frame_length", 16'(want.frame_length), 16'(m_tdata[23:16]));
        check_field("frame_address", want.frame_address, m_tdata[39:24]);
        check_field("is_last", 16'(want.is_last), 16'(m_tlast));
        check_field("checksum_ok", 16'(want.checksum_ok), 16'(m_tuser));
      end
    end
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    cfg_t c;
    bit   paused;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_OWN_ADDRESS;
    cfg_data  <= 16'h0000;
    cfg_shadow = '{16'h0001, 16'hFFFF, 8'd251};
    fr_pos  = POS_HUNT;
    fr_len  = 16'h0000;
    fr_addr = 16'h0000;
    fr_xor  = 8'h00;
    tx_idle_pct = 28;
    rx_idle_pct = 50;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed walk with the registers at their reset values
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_byte(DIR_TABLE[i].rx_byte, DIR_TABLE[i].typed, DIR_TABLE[i].res);
    end

    for (int p = 0; p < PHASES; p++) begin
      // let the block go idle before touching the registers
      drain_results();
      repeat (8) @(posedge clk);
      c = PHASE_CFG[p];
      if (p == 3) begin
        c.own_address   = 16'($urandom_range(65535));
        c.fixed_address = 16'($urandom_range(65535));
        c.max_length    = 8'($urandom_range(2, 251));
      end
      write_regs(c);
      case (p / 2)
        0: begin
          tx_idle_pct = 28;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 28;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      paused = 1'b0;
      sent_count = 0;
      while (sent_count < PHASE_ITEMS) begin
        send_random_unit();
        // sender holds off now and then until the output side has caught up
        if ((!paused && sent_count >= PHASE_ITEMS / 2) || $urandom_range(49) == 0) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 4000 && pending_results.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: results missing expected %0d more actual none", $time,
               pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/asfr_pkg.sv
rtl/core/asfr_parser.sv
rtl/core/asfr_out_buf.sv
rtl/core/addressed_serial_frame_receiver.sv
tb/tb_addressed_serial_frame_receiver.sv
